>>> rtl/hbr_pkg.sv
// shared types, register indexes and saturating helpers of the histogram bin regrouper
package hbr_pkg;

  typedef enum logic [2:0] {
    CFG_START_EDGE = 3'd0,
    CFG_STEP_SIZE  = 3'd1,
    CFG_LOG_STEP   = 3'd2,
    CFG_END_EDGE   = 3'd3,
    CFG_DIST_MODE  = 3'd4
  } cfg_index_e;

  localparam logic [31:0] START_EDGE_RST = 32'h0000_0000;
  localparam logic [31:0] STEP_SIZE_RST  = 32'h0001_0000;
  localparam logic [31:0] END_EDGE_RST   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]        bin_lo;
    logic [31:0]        bin_hi;
    logic signed [31:0] counts;
    logic [31:0]        error;
    logic               new_spectrum;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        group_lo;
    logic [31:0]        group_hi;
    logic signed [31:0] group_value;
    logic [31:0]        group_error;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_edge;
    logic [31:0] step_size;
    logic        log_step;
    logic [31:0] end_edge;
    logic        distribution_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        lo;
    logic [31:0]        hi;
    logic signed [63:0] value_sum;
    logic [63:0]        error_square_sum;
    logic               dist_mode;
  } job_t;

  function automatic logic signed [63:0] add_sat_s(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      add_sat_s = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      add_sat_s = s[63:0];
    end
  endfunction

  function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat_u = s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

>>> rtl/hbr_fifo.sv
// small transaction queue used between the parts of the regrouper
module hbr_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

>>> rtl/hbr_front.sv
// front part: takes bins, tracks boundaries and sums, hands closed groups to the back
module hbr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbr_pkg::cfg_t    cfg_i,
  input  logic             push_i,
  input  hbr_pkg::in_item_t item_i,
  output logic             full_o,
  output logic             job_push_o,
  output hbr_pkg::job_t    job_o,
  input  logic             job_full_i
);
  import hbr_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_EVAL  = 5'b00010,
    F_SQ    = 5'b00100,
    F_ACC   = 5'b01000,
    F_CLOSE = 5'b10000
  } front_state_e;

  front_state_e       state_q, state_d;
  in_item_t           item_q;
  logic               open_q, open_d, done_q, done_d;
  logic [31:0]        bnd_q, bnd_d;
  logic signed [63:0] vsum_q, vsum_d;
  logic [63:0]        esq_q, esq_d;
  logic signed [63:0] pv_q, pv_d;
  logic [63:0]        pa_q, pa_d, pt_q, pt_d, sq_q, sq_d;
  logic               hit_q, hit_d;

  logic               open_eff, done_eff, lo_ok;
  logic [31:0]        bnd_new, width;
  logic signed [64:0] pv_full;
  logic [63:0]        target;

  assign full_o = (state_q != F_IDLE);

  always_comb begin
    open_eff = item_q.new_spectrum ? 1'b0 : open_q;
    done_eff = item_q.new_spectrum ? 1'b0 : done_q;
    lo_ok    = (item_q.bin_lo >= cfg_i.start_edge);
    bnd_new  = (!open_eff && lo_ok) ? item_q.bin_lo : bnd_q;
    width    = (item_q.bin_hi > item_q.bin_lo) ? item_q.bin_hi - item_q.bin_lo : 32'd0;
    pv_full  = $signed(item_q.counts) * $signed({1'b0, width});
    target   = {32'd0, bnd_q} + (cfg_i.log_step ? {16'd0, pt_q[63:16]}
                                                : {32'd0, cfg_i.step_size});
  end

  always_comb begin
    state_d    = state_q;
    open_d     = open_q;
    done_d     = done_q;
    bnd_d      = bnd_q;
    vsum_d     = vsum_q;
    esq_d      = esq_q;
    pv_d       = pv_q;
    pa_d       = pa_q;
    pt_d       = pt_q;
    sq_d       = sq_q;
    hit_d      = hit_q;
    job_push_o = 1'b0;
    job_o      = '{lo: bnd_q, hi: item_q.bin_hi, value_sum: vsum_q,
                   error_square_sum: esq_q, dist_mode: cfg_i.distribution_mode};
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_EVAL;
        end
      end
      F_EVAL: begin
        pv_d = cfg_i.distribution_mode ? pv_full[63:0] : 64'(item_q.counts);
        pa_d = cfg_i.distribution_mode ? item_q.error * width
                                       : item_q.error * item_q.error;
        pt_d = bnd_new * cfg_i.step_size;
        if (item_q.new_spectrum) begin
          open_d = 1'b0;
          done_d = 1'b0;
          bnd_d  = '0;
          vsum_d = '0;
          esq_d  = '0;
        end
        if (done_eff) begin
          state_d = F_IDLE;
        end else if (open_eff) begin
          state_d = F_SQ;
        end else if (lo_ok) begin
          bnd_d   = item_q.bin_lo;
          open_d  = 1'b1;
          vsum_d  = '0;
          esq_d   = '0;
          state_d = F_SQ;
        end else begin
          if (item_q.bin_hi >= cfg_i.start_edge) begin
            bnd_d  = item_q.bin_hi;
            open_d = 1'b1;
            vsum_d = '0;
            esq_d  = '0;
          end
          state_d = F_IDLE;
        end
      end
      F_SQ: begin
        if (!cfg_i.distribution_mode) begin
          sq_d = pa_q;
        end else if (pa_q[63:48] != '0) begin
          sq_d = {64{1'b1}};
        end else begin
          sq_d = pa_q[47:16] * pa_q[47:16];
        end
        state_d = F_ACC;
      end
      F_ACC: begin
        vsum_d  = add_sat_s(vsum_q, pv_q);
        esq_d   = add_sat_u(esq_q, sq_q);
        hit_d   = ({32'd0, item_q.bin_hi} >= target);
        state_d = F_CLOSE;
      end
      F_CLOSE: begin
        if (!hit_q) begin
          state_d = F_IDLE;
        end else if (item_q.bin_hi > cfg_i.end_edge) begin
          done_d  = 1'b1;
          open_d  = 1'b0;
          vsum_d  = '0;
          esq_d   = '0;
          state_d = F_IDLE;
        end else if (!job_full_i) begin
          job_push_o = 1'b1;
          bnd_d      = item_q.bin_hi;
          vsum_d     = '0;
          esq_d      = '0;
          state_d    = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      open_q  <= 1'b0;
      done_q  <= 1'b0;
      bnd_q   <= '0;
      vsum_q  <= '0;
      esq_q   <= '0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      done_q  <= done_d;
      bnd_q   <= bnd_d;
      vsum_q  <= vsum_d;
      esq_q   <= esq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      item_q <= item_i;
    end
    pv_q  <= pv_d;
    pa_q  <= pa_d;
    pt_q  <= pt_d;
    sq_q  <= sq_d;
    hit_q <= hit_d;
  end
endmodule

>>> rtl/hbr_back.sv
// back part: square root per closed group, width division in distribution mode, saturation of results
module hbr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  hbr_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               res_push_o,
  output hbr_pkg::out_item_t res_o,
  input  logic               res_full_i
);
  import hbr_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQRT = 5'b00010,
    B_DIVV = 5'b00100,
    B_DIVE = 5'b01000,
    B_OUT  = 5'b10000
  } back_state_e;

  back_state_e        state_q, state_d;
  job_t               job_q;
  logic [63:0]        x_q, x_d, r_q, r_d, bit_q, bit_d, dvd_q, dvd_d;
  logic [31:0]        rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [31:0] val_q, val_d;
  logic [31:0]        err_q, err_d;

  logic [31:0]        width;
  logic [63:0]        rb, vmag;
  logic [32:0]        rem_sh;
  logic               ge, neg;
  logic [63:0]        dvd_n;
  logic [31:0]        rem_n;

  always_comb begin
    width  = job_q.hi - job_q.lo;
    rb     = r_q + bit_q;
    neg    = job_q.value_sum[63];
    vmag   = neg ? 64'(-job_q.value_sum) : 64'(job_q.value_sum);
    rem_sh = {rem_q, dvd_q[63]};
    ge     = (rem_sh >= {1'b0, width});
    rem_n  = ge ? 32'(rem_sh - {1'b0, width}) : rem_sh[31:0];
    dvd_n  = {dvd_q[62:0], ge};
  end

  assign res_o = '{group_lo: job_q.lo, group_hi: job_q.hi,
                   group_value: val_q, group_error: err_q};

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    r_d        = r_q;
    bit_d      = bit_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    err_d      = err_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          x_d       = job_i.error_square_sum;
          r_d       = '0;
          bit_d     = 64'd1 << 62;
          state_d   = B_SQRT;
        end
      end
      B_SQRT: begin
        if (bit_q != '0) begin
          if (x_q >= rb) begin
            x_d = x_q - rb;
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else if (!job_q.dist_mode) begin
          if (job_q.value_sum > 64'sd2147483647) begin
            val_d = 32'sh7FFF_FFFF;
          end else if (job_q.value_sum < -64'sd2147483648) begin
            val_d = 32'sh8000_0000;
          end else begin
            val_d = job_q.value_sum[31:0];
          end
          err_d   = (r_q[63:32] != '0) ? 32'hFFFF_FFFF : r_q[31:0];
          state_d = B_OUT;
        end else if (width == '0) begin
          val_d   = '0;
          err_d   = '0;
          state_d = B_OUT;
        end else begin
          dvd_d   = vmag;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = B_DIVV;
        end
      end
      B_DIVV: begin
        dvd_d = dvd_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          if (neg) begin
            val_d = (dvd_n > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dvd_n);
          end else begin
            val_d = (dvd_n > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd_n[31:0];
          end
          dvd_d   = {r_q[47:0], 16'd0};
          rem_d   = '0;
          state_d = B_DIVE;
        end
      end
      B_DIVE: begin
        dvd_d = dvd_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          err_d   = (dvd_n[63:32] != '0) ? 32'hFFFF_FFFF : dvd_n[31:0];
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    val_q <= val_d;
    err_q <= err_d;
  end
endmodule

>>> rtl/histogram_bin_regrouper_unit.sv
// top level of the histogram bin regrouper
//
// old bins enter through a queue-style port: a transaction is taken when push
// is high and full is low. new_spectrum on a bin clears all grouping state.
// closed groups leave through a second queue: while empty is low the oldest
// group sits on out_data_o and is removed when pop is high.
// configuration is written over cfg_valid_i/cfg_ready_o with a register index
// and 32-bit data; ready is always high and writes belong in idle periods.
// the front works on one bin at a time and takes no new one until it is done:
// accept, classify, square, accumulate and compare, close, where a bin that
// adds to no group ends at classify. a closing bin hands its group to the
// back through a job queue of JOB_DEPTH entries. the back works on one group
// at a time: a pop, 32 square root steps, a decision and a push, plus in
// distribution mode two 64-step divisions by the group width, skipped when
// the width is zero. results collect in a queue of RES_DEPTH entries; when it
// fills under a stalled receiver, the back and then the front hold and full
// stays high.
// reset empties both queues, clears grouping state and loads register defaults.
module histogram_bin_regrouper_unit #(
  parameter int JOB_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hbr_pkg::in_item_t  in_data_i,
  output logic               empty,
  input  logic               pop,
  output hbr_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import hbr_pkg::*;

  cfg_t      cfg_q, cfg_d;
  job_t      job_w, job_r;
  out_item_t res_w;
  logic      job_push, job_full, job_pop, job_empty;
  logic      res_push, res_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_EDGE: cfg_d.start_edge        = cfg_data_i;
        CFG_STEP_SIZE:  cfg_d.step_size         = cfg_data_i;
        CFG_LOG_STEP:   cfg_d.log_step          = cfg_data_i[0];
        CFG_END_EDGE:   cfg_d.end_edge          = cfg_data_i;
        CFG_DIST_MODE:  cfg_d.distribution_mode = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_edge: START_EDGE_RST, step_size: STEP_SIZE_RST, log_step: 1'b0,
                 end_edge: END_EDGE_RST, distribution_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .item_i     (in_data_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_w),
    .job_full_i (job_full)
  );

  hbr_fifo #(.DEPTH(JOB_DEPTH), .WIDTH($bits(job_t))) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_w),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_r),
    .empty_o (job_empty)
  );

  hbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_r),
    .job_pop_o   (job_pop),
    .res_push_o  (res_push),
    .res_o       (res_w),
    .res_full_i  (res_full)
  );

  hbr_fifo #(.DEPTH(RES_DEPTH), .WIDTH($bits(out_item_t))) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("front did not go busy after taking a bin");

  a_job_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job queue written while full");

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_job_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("back took a job from an empty queue");
endmodule
